@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on the block clock, off during reset
`define CHK_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
	`CHK_PROP(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
	`CHK_PROP(lbl, (ante) |=> (cons), msg)

`endif

@@ hdl/s2cd_pkg.sv @@
// constants, widths and calendar tables for the seconds to date converter
package s2cd_pkg;

	localparam int NumStages = 7;

	localparam int SecsW  = 32;
	localparam int DaysW  = 16;
	localparam int TodW   = 17;
	localparam int YearW  = 12;
	localparam int MonthW = 4;
	localparam int MdayW  = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int SecW   = 6;
	localparam int WdayW  = 3;
	localparam int DoyW   = 9;

	// seconds per day is 675 << 7, the low seven bits pass straight through
	localparam logic [9:0]  DayDivisor = 10'd675;
	localparam logic [25:0] DayRcp     = 26'd50903316;
	localparam int          DayShift   = 35;

	localparam logic [10:0] DaysPerGroup = 11'd1461;
	localparam logic [15:0] GroupRcp     = 16'd45934;
	localparam int          GroupShift   = 26;

	localparam logic [2:0]  DaysPerWeek = 3'd7;
	localparam logic [16:0] WeekRcp     = 17'd74899;
	localparam int          WeekShift   = 19;
	localparam logic [2:0]  BaseWeekday = 3'd6;

	// hour: (tod >> 4) / 225
	localparam logic [11:0] SecsPerHour = 12'd3600;
	localparam logic [12:0] HourRcp     = 13'd4661;
	localparam int          HourShift   = 20;

	// minute: (msec >> 2) / 15
	localparam logic [5:0]  SecsPerMin = 6'd60;
	localparam logic [10:0] MinRcp     = 11'd1093;
	localparam int          MinShift   = 14;

	localparam logic [YearW-1:0] BaseYear = 12'd2000;

	// day within the four-year group at which each year starts
	function automatic logic [10:0] year_start(input logic [1:0] yi);
		logic [10:0] v;
		unique case (yi)
			2'd0: v = 11'd0;
			2'd1: v = 11'd366;
			2'd2: v = 11'd731;
			2'd3: v = 11'd1096;
			default: v = 11'd0;
		endcase
		return v;
	endfunction

	// days before month m, one extra from march on in a leap year
	function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DoyW-1:0] v;
		unique case (m)
			4'd0:  v = 9'd0;
			4'd1:  v = 9'd31;
			4'd2:  v = 9'd59;
			4'd3:  v = 9'd90;
			4'd4:  v = 9'd120;
			4'd5:  v = 9'd151;
			4'd6:  v = 9'd181;
			4'd7:  v = 9'd212;
			4'd8:  v = 9'd243;
			4'd9:  v = 9'd273;
			4'd10: v = 9'd304;
			4'd11: v = 9'd334;
			4'd12: v = 9'd365;
			default: v = 9'd365;
		endcase
		if (leap && m >= 4'd2) begin
			v = v + 9'd1;
		end
		return v;
	endfunction

endpackage

@@ hdl/s2cd_in_if.sv @@
// request channel carrying the second count
interface s2cd_in_if import s2cd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SecsW-1:0] elapsed_seconds;

	modport source (output valid, output elapsed_seconds, input ready);
	modport sink (input valid, input elapsed_seconds, output ready);
endinterface

@@ hdl/s2cd_out_if.sv @@
// result channel carrying the calendar fields
interface s2cd_out_if import s2cd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [YearW-1:0]  year;
	logic [MonthW-1:0] month;
	logic [MdayW-1:0]  day_of_month;
	logic [HourW-1:0]  hour;
	logic [MinW-1:0]   minute;
	logic [SecW-1:0]   second;
	logic [WdayW-1:0]  weekday;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output weekday, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input weekday, output ready);
endinterface

@@ hdl/s2cd_day_split.sv @@
// stages one to three: second count into day number and second of day
module s2cd_day_split import s2cd_pkg::*; (
	input  logic             clk,
	input  logic [2:0]       adv,
	input  logic [SecsW-1:0] secs,
	output logic [DaysW-1:0] days_s3,
	output logic [TodW-1:0]  tod_s3
);

	logic [24:0]       x_s1;
	logic [6:0]        lo_s1;
	logic [50:0]       prod_s1;
	logic [DaysW-1:0]  qe_s2;
	logic [10:0]       rem_s2;
	logic [6:0]        lo_s2;

	logic [DaysW-1:0]  qe;
	logic [25:0]       rem_full;
	logic              fix;
	logic [10:0]       rem_fixed;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s1    <= secs[31:7];
			lo_s1   <= secs[6:0];
			prod_s1 <= 51'(secs[31:7]) * 51'(DayRcp);
		end
	end

	// estimate is the true quotient or one below it
	always_comb begin
		qe       = prod_s1[50:DayShift];
		rem_full = {1'b0, x_s1} - 26'(qe) * 26'(DayDivisor);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			qe_s2  <= qe;
			rem_s2 <= rem_full[10:0];
			lo_s2  <= lo_s1;
		end
	end

	always_comb begin
		fix       = rem_s2 >= 11'(DayDivisor);
		rem_fixed = fix ? rem_s2 - 11'(DayDivisor) : rem_s2;
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			days_s3 <= qe_s2 + DaysW'(fix);
			tod_s3  <= {rem_fixed[9:0], lo_s2};
		end
	end

endmodule

@@ hdl/s2cd_date.sv @@
// stages four to seven: day number into year, month, day and weekday
module s2cd_date import s2cd_pkg::*; (
	input  logic              clk,
	input  logic [3:0]        adv,
	input  logic [DaysW-1:0]  days,
	output logic [YearW-1:0]  year_s7,
	output logic [MonthW-1:0] month_s7,
	output logic [MdayW-1:0]  mday_s7,
	output logic [WdayW-1:0]  wday_s7
);

	logic [DaysW-1:0]  days_s4;
	logic [31:0]       gp_s4;
	logic [32:0]       wp_s4;
	logic [5:0]        grp_s5;
	logic [10:0]       dg_s5;
	logic [2:0]        wr_s5;
	logic [YearW-1:0]  year_s6;
	logic [DoyW-1:0]   doy_s6;
	logic              leap_s6;
	logic [WdayW-1:0]  wday_s6;

	logic [5:0]        grp;
	logic [13:0]       wq;
	logic [DaysW-1:0]  dg_full;
	logic [DaysW-1:0]  wr_full;
	logic [1:0]        yi;
	logic [10:0]       doy_full;
	logic [3:0]        wsum;
	logic [MonthW-1:0] mon;
	logic [DoyW-1:0]   mday_full;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			days_s4 <= days;
			gp_s4   <= 32'(days) * 32'(GroupRcp);
			wp_s4   <= 33'(days) * 33'(WeekRcp);
		end
	end

	always_comb begin
		grp     = gp_s4[31:GroupShift];
		wq      = wp_s4[32:WeekShift];
		dg_full = days_s4 - 16'(grp) * 16'(DaysPerGroup);
		wr_full = days_s4 - 16'(wq) * 16'(DaysPerWeek);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			grp_s5 <= grp;
			dg_s5  <= dg_full[10:0];
			wr_s5  <= wr_full[2:0];
		end
	end

	always_comb begin
		priority if (dg_s5 >= year_start(2'd3)) begin
			yi = 2'd3;
		end else if (dg_s5 >= year_start(2'd2)) begin
			yi = 2'd2;
		end else if (dg_s5 >= year_start(2'd1)) begin
			yi = 2'd1;
		end else begin
			yi = 2'd0;
		end
		doy_full = dg_s5 - year_start(yi);
		wsum     = 4'(wr_s5) + 4'(BaseWeekday);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			year_s6 <= BaseYear + {4'd0, grp_s5, yi};
			doy_s6  <= doy_full[DoyW-1:0];
			leap_s6 <= yi == 2'd0;
			wday_s6 <= (wsum >= 4'(DaysPerWeek)) ? 3'(wsum - 4'(DaysPerWeek)) : wsum[2:0];
		end
	end

	// first month whose end lies beyond the day of year
	always_comb begin
		mon = 4'd12;
		for (int m = 12; m >= 1; m--) begin
			if (doy_s6 < days_before(4'(m), leap_s6)) begin
				mon = 4'(m);
			end
		end
		mday_full = doy_s6 - days_before(mon - 4'd1, leap_s6) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			year_s7  <= year_s6;
			month_s7 <= mon;
			mday_s7  <= mday_full[MdayW-1:0];
			wday_s7  <= wday_s6;
		end
	end

endmodule

@@ hdl/s2cd_time.sv @@
// stages four to seven: second of day into hour, minute and second
module s2cd_time import s2cd_pkg::*; (
	input  logic             clk,
	input  logic [3:0]       adv,
	input  logic [TodW-1:0]  tod,
	output logic [HourW-1:0] hour_s7,
	output logic [MinW-1:0]  minute_s7,
	output logic [SecW-1:0]  second_s7
);

	logic [TodW-1:0]  tod_s4;
	logic [25:0]      hp_s4;
	logic [HourW-1:0] hour_s5;
	logic [11:0]      msec_s5;
	logic [HourW-1:0] hour_s6;
	logic [11:0]      msec_s6;
	logic [20:0]      mp_s6;

	logic [HourW-1:0] hour;
	logic [TodW-1:0]  msec_full;
	logic [MinW-1:0]  minute;
	logic [11:0]      sec_full;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			tod_s4 <= tod;
			hp_s4  <= 26'(tod[16:4]) * 26'(HourRcp);
		end
	end

	always_comb begin
		hour      = hp_s4[24:HourShift];
		msec_full = tod_s4 - 17'(hour) * 17'(SecsPerHour);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			hour_s5 <= hour;
			msec_s5 <= msec_full[11:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			hour_s6 <= hour_s5;
			msec_s6 <= msec_s5;
			mp_s6   <= 21'(msec_s5[11:2]) * 21'(MinRcp);
		end
	end

	always_comb begin
		minute   = mp_s6[19:MinShift];
		sec_full = msec_s6 - 12'(minute) * 12'(SecsPerMin);
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			hour_s7   <= hour_s6;
			minute_s7 <= minute;
			second_s7 <= sec_full[SecW-1:0];
		end
	end

endmodule

@@ hdl/seconds_to_calendar_date.sv @@
// top level: seven stage pipeline from second count to calendar date
// throughput: one request per cycle while the result side is ready
// a stage holds its item while the stage after it is full and stalled, bubbles fill
// reset clears only the stage valid bits, data registers are not reset
`include "assert_macros.svh"

module seconds_to_calendar_date import s2cd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	s2cd_in_if.sink    stamp,
	s2cd_out_if.source date
);

	logic [NumStages-1:0] stage_valid_q;
	logic [NumStages-1:0] adv;
	logic [DaysW-1:0]     days_s3;
	logic [TodW-1:0]      tod_s3;

	// a stage moves when it is empty or its successor moves
	always_comb begin
		adv[NumStages-1] = !stage_valid_q[NumStages-1] || date.ready;
		for (int i = NumStages - 2; i >= 0; i--) begin
			adv[i] = !stage_valid_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (adv[0]) begin
				stage_valid_q[0] <= stamp.valid;
			end
			for (int i = 1; i < NumStages; i++) begin
				if (adv[i]) begin
					stage_valid_q[i] <= stage_valid_q[i-1];
				end
			end
		end
	end

	assign stamp.ready = adv[0];
	assign date.valid  = stage_valid_q[NumStages-1];

	s2cd_day_split u_day_split (
		.clk     (clk),
		.adv     (adv[2:0]),
		.secs    (stamp.elapsed_seconds),
		.days_s3 (days_s3),
		.tod_s3  (tod_s3)
	);

	s2cd_date u_date (
		.clk      (clk),
		.adv      (adv[6:3]),
		.days     (days_s3),
		.year_s7  (date.year),
		.month_s7 (date.month),
		.mday_s7  (date.day_of_month),
		.wday_s7  (date.weekday)
	);

	s2cd_time u_time (
		.clk       (clk),
		.adv       (adv[6:3]),
		.tod       (tod_s3),
		.hour_s7   (date.hour),
		.minute_s7 (date.minute),
		.second_s7 (date.second)
	);

	`CHK_NEXT(a_request_enters, stamp.valid && stamp.ready, stage_valid_q[0], "request lost")
	`CHK_IMPLY(a_full_stall, (&stage_valid_q) && !date.ready, !stamp.ready, "request into full pipe")
	`CHK_IMPLY(a_month_range, date.valid, date.month >= 4'd1 && date.month <= 4'd12, "bad month")
	`CHK_IMPLY(a_mday_range, date.valid, date.day_of_month != 5'd0, "zero day of month")
	`CHK_IMPLY(a_hour_minute, date.valid, date.hour < 5'd24 && date.minute < 6'd60, "bad time")
	`CHK_IMPLY(a_second_wday, date.valid, date.second < 6'd60 && date.weekday < 3'd7, "bad time")

endmodule

@@ verif/seconds_to_calendar_date_tb.sv @@
// testbench for the seconds to calendar date converter, table-driven and random requests
`timescale 1ns / 1ps

module seconds_to_calendar_date_tb;
	import s2cd_pkg::*;

	localparam int ClkHalf       = 10;
	localparam int ResetCycles   = 5;
	localparam int RandomItems   = 900;
	localparam int HoldOffCycles = 60;
	localparam int StallLimit    = 2000;
	localparam int TailCycles    = 4 * NumStages;
	localparam int ModeSpan      = 64;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned QuadDays    = 1461;
	localparam int unsigned EpochYear   = 2000;
	localparam int unsigned EpochDow    = 6;
	localparam int unsigned LastQuad    = 33;
	localparam int unsigned CenturyQuad = 25;

	localparam logic [WdayW-1:0] WdTuesday  = 3'd2;
	localparam logic [WdayW-1:0] WdSaturday = 3'd6;

	localparam int unsigned YearFirst [4]   = '{0, 366, 731, 1096};
	localparam int unsigned MonthFirst [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int unsigned MonthLen [12]   =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [MdayW-1:0]  day_of_month;
		logic [HourW-1:0]  hour;
		logic [MinW-1:0]   minute;
		logic [SecW-1:0]   second;
		logic [WdayW-1:0]  weekday;
	} cal_date_t;

	typedef struct packed {
		logic [SecsW-1:0] secs;
		logic             fixed;
		cal_date_t        want;
	} stamp_row_t;

	typedef struct {
		logic [SecsW-1:0] secs;
		cal_date_t        want;
	} pending_date_t;

	localparam cal_date_t NoDate = '0;

	localparam int NumRows = 24;
	localparam stamp_row_t DirectedRows [NumRows] = '{
		'{32'd0,          1'b1, '{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, WdSaturday}},
		'{32'd86399,      1'b1, '{12'd2000, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, WdSaturday}},
		'{32'hFFFF_FFFF,  1'b1, '{12'd2136, 4'd2, 5'd6, 5'd6, 6'd28, 6'd15, WdTuesday}},
		'{32'd86400,      1'b0, NoDate},
		'{32'd3599,       1'b0, NoDate},
		'{32'd3600,       1'b0, NoDate},
		'{32'd45659,      1'b0, NoDate},
		// leap day of the first year and the day after
		'{32'd5097600,    1'b0, NoDate},
		'{32'd5184000,    1'b0, NoDate},
		'{32'd31536000,   1'b0, NoDate},
		'{32'd31622400,   1'b0, NoDate},
		'{32'd36633600,   1'b0, NoDate},
		'{32'd36720000,   1'b0, NoDate},
		// last second of a four-year group, then the next group
		'{32'd126230399,  1'b0, NoDate},
		'{32'd126230400,  1'b0, NoDate},
		// 2100 keeps its 29 february
		'{32'd3160771200, 1'b0, NoDate},
		'{32'd3160857600, 1'b0, NoDate},
		'{32'd3160944000, 1'b0, NoDate},
		'{32'd3187296000, 1'b0, NoDate},
		'{32'd3187382400, 1'b0, NoDate},
		'{32'h8000_0000,  1'b0, NoDate},
		'{32'h7FFF_FFFF,  1'b0, NoDate},
		'{32'h5555_5555,  1'b0, NoDate},
		'{32'hAAAA_AAAA,  1'b0, NoDate}
	};

	logic clk;
	logic arst_n;

	s2cd_in_if  stamp_ch ();
	s2cd_out_if date_ch ();

	seconds_to_calendar_date dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp_ch),
		.date   (date_ch)
	);

	pending_date_t pending_dates [$];
	int            mismatches = 0;
	bit            tx_steady  = 1'b0;
	bit            rx_steady  = 1'b0;
	bit            rx_hold_req = 1'b0;

	initial clk = 1'b0;
	always #ClkHalf clk = ~clk;

	function automatic int unsigned days_before_month(input int unsigned mi, input bit leap);
		return MonthFirst[mi] + ((leap && mi >= 2) ? 1 : 0);
	endfunction

	function automatic cal_date_t predict_date(input logic [SecsW-1:0] secs);
		int unsigned day_count;
		int unsigned tod;
		int unsigned in_quad;
		int unsigned yr;
		int unsigned yi;
		int unsigned mi;
		bit          leap;
		cal_date_t   d;
		day_count = secs / SecsPerDay;
		tod       = secs % SecsPerDay;
		yr        = (day_count / QuadDays) * 4;
		in_quad   = day_count % QuadDays;
		yi        = 0;
		while (yi < 3 && in_quad >= YearFirst[yi + 1]) begin
			yi++;
		end
		in_quad -= YearFirst[yi];
		leap     = (yi == 0);
		mi       = 0;
		while (mi < 11 && in_quad >= days_before_month(mi + 1, leap)) begin
			mi++;
		end
		d.year         = YearW'(EpochYear + yr + yi);
		d.month        = MonthW'(mi + 1);
		d.day_of_month = MdayW'(in_quad - days_before_month(mi, leap) + 1);
		d.hour         = HourW'(tod / 3600);
		d.minute       = MinW'((tod / 60) % 60);
		d.second       = SecW'(tod % 60);
		d.weekday      = WdayW'((day_count % 7 + EpochDow) % 7);
		return d;
	endfunction

	// mix of raw words, random days, month and year edges, the 2100 window and the top of the range
	function automatic logic [SecsW-1:0] draw_stamp();
		int unsigned quad;
		int unsigned yi;
		int unsigned mi;
		int unsigned day_count;
		int unsigned tod;
		bit          leap;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 49709) * SecsPerDay + $urandom_range(0, SecsPerDay - 1);
			2: begin
				quad      = ($urandom_range(0, 3) == 0) ? CenturyQuad : $urandom_range(0, LastQuad);
				yi        = $urandom_range(0, 3);
				mi        = $urandom_range(0, 11);
				leap      = (yi == 0);
				day_count = quad * QuadDays + YearFirst[yi] + days_before_month(mi, leap);
				if ($urandom_range(0, 1) == 1) begin
					day_count += MonthLen[mi] + ((leap && mi == 1) ? 1 : 0) - 1;
				end
				case ($urandom_range(0, 2))
					0: tod = 0;
					1: tod = SecsPerDay - 1;
					default: tod = $urandom_range(0, SecsPerDay - 1);
				endcase
				return day_count * SecsPerDay + tod;
			end
			default: return 32'hFFFF_FFFF - $urandom_range(0, 3 * SecsPerDay);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [SecsW-1:0] secs,
			input logic [31:0] got, input logic [31:0] want);
		$display("mismatch: %s for %0d seconds, got %0d, expected %0d", what, secs, got, want);
		mismatches++;
	endtask

	task automatic send_request(input logic [SecsW-1:0] secs, input cal_date_t want);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			stamp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stamp_ch.valid           <= 1'b1;
		stamp_ch.elapsed_seconds <= secs;
		do @(posedge clk); while (!stamp_ch.ready);
		pending_dates.push_back('{secs, want});
	endtask

	task automatic drain_dates();
		stamp_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_dates.size() != 0);
	endtask

	// request side
	initial begin
		logic [SecsW-1:0] secs;
		arst_n = 1'b0;
		stamp_ch.valid           <= 1'b0;
		stamp_ch.elapsed_seconds <= '0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int row = 0; row < NumRows; row++) begin
			secs = DirectedRows[row].secs;
			send_request(secs, DirectedRows[row].fixed ? DirectedRows[row].want : predict_date(secs));
		end
		drain_dates();
		for (int n = 0; n < RandomItems; n++) begin
			if (n % ModeSpan == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
			end
			// long result stall while requests keep coming, then later a full drain
			if (n == RandomItems / 3) begin
				rx_hold_req = 1'b1;
			end
			if (n == 2 * RandomItems / 3) begin
				drain_dates();
			end
			secs = draw_stamp();
			send_request(secs, predict_date(secs));
		end
		drain_dates();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// result side ready
	initial begin
		int wait_cycles;
		int seen;
		seen = 0;
		date_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (seen % ModeSpan == 0) begin
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			if (rx_hold_req) begin
				wait_cycles = HoldOffCycles;
				rx_hold_req = 1'b0;
			end else begin
				wait_cycles = rx_steady ? 0 : $urandom_range(0, 3);
			end
			if (wait_cycles > 0) begin
				date_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			date_ch.ready <= 1'b1;
			do @(posedge clk); while (!(date_ch.valid && date_ch.ready));
			seen++;
		end
	end

	// result checker
	always @(posedge clk) begin
		cal_date_t     got;
		pending_date_t exp_date;
		if (arst_n && date_ch.valid && date_ch.ready) begin
			got = '{date_ch.year, date_ch.month, date_ch.day_of_month, date_ch.hour,
				date_ch.minute, date_ch.second, date_ch.weekday};
			if (pending_dates.size() == 0) begin
				report_mismatch("date with no request outstanding, year", '0, 32'(got.year), '0);
			end else begin
				exp_date = pending_dates.pop_front();
				if (got.year !== exp_date.want.year)
					report_mismatch("year", exp_date.secs, 32'(got.year), 32'(exp_date.want.year));
				if (got.month !== exp_date.want.month)
					report_mismatch("month", exp_date.secs, 32'(got.month), 32'(exp_date.want.month));
				if (got.day_of_month !== exp_date.want.day_of_month)
					report_mismatch("day_of_month", exp_date.secs, 32'(got.day_of_month),
						32'(exp_date.want.day_of_month));
				if (got.hour !== exp_date.want.hour)
					report_mismatch("hour", exp_date.secs, 32'(got.hour), 32'(exp_date.want.hour));
				if (got.minute !== exp_date.want.minute)
					report_mismatch("minute", exp_date.secs, 32'(got.minute), 32'(exp_date.want.minute));
				if (got.second !== exp_date.want.second)
					report_mismatch("second", exp_date.secs, 32'(got.second), 32'(exp_date.want.second));
				if (got.weekday !== exp_date.want.weekday)
					report_mismatch("weekday", exp_date.secs, 32'(got.weekday),
						32'(exp_date.want.weekday));
			end
		end
	end

	// no progress on either channel for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((stamp_ch.valid && stamp_ch.ready) || (date_ch.valid && date_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= StallLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
